[hw/rtl/iots_pkg.sv]
// Package for the I/O transaction statistics block: request/result structs,
// command codes, selector codes and shared constants. No dependencies.
package iots_pkg;

    localparam int DEV_W = 4;
    localparam int DEFAULT_NUM_DEVICES = 16;
    localparam int MASK_W = 16;

    typedef enum logic [1:0]
    {
        CMD_START = 2'd0,
        CMD_END   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    localparam logic [4:0] SEL_STARTS = 5'd0;
    localparam logic [4:0] SEL_ENDS   = 5'd1;
    localparam logic [4:0] SEL_BUSY   = 5'd2;
    localparam logic [4:0] SEL_SINCE  = 5'd3;
    localparam logic [2:0] GRP_CNT    = 3'd0;
    localparam logic [2:0] GRP_BYTES  = 3'd1;
    localparam logic [2:0] GRP_OPS    = 3'd2;
    localparam logic [2:0] GRP_DUR    = 3'd3;
    localparam logic [2:0] GRP_TAGS   = 3'd4;
    localparam logic [1:0] TAG_NONE   = 2'd3;

    typedef struct packed
    {
        logic [1:0]  cmd;
        logic [3:0]  device;
        logic [63:0] now_time;
        logic        has_start_time;
        logic [63:0] start_time;
        logic [31:0] byte_count;
        logic [1:0]  transfer_kind;
        logic [1:0]  tag_kind;
        logic [4:0]  stat_select;
    } in_item_t;

    typedef struct packed
    {
        logic [3:0]  device_echo;
        logic [63:0] stat_value;
    } out_item_t;

    typedef struct packed
    {
        in_item_t item;
        logic     dev_ok;
        logic     tag_ok;
    } op_t;

endpackage

[hw/rtl/iots_front.sv]
// Front end: accepts requests, classifies them and pushes them into a
// two-entry queue. Depends on iots_pkg.
module iots_front
    import iots_pkg::*;
#(
    parameter int NUM_DEVICES = DEFAULT_NUM_DEVICES
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_data,
    input  logic [MASK_W-1:0] mask,
    output logic              q_valid,
    input  logic              q_pop,
    output op_t               q_data
);

    op_t        mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    op_t        op_in;

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = mem_reg[rp_reg];

    always_comb
    begin
        op_in.item   = in_data;
        op_in.dev_ok = ({28'd0, in_data.device} < 32'(NUM_DEVICES));
        op_in.tag_ok = !mask[in_data.device] && (in_data.tag_kind != TAG_NONE);
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ q_pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= op_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

[hw/rtl/iots_back.sv]
// Back end: per-device counter table with a registered read, then update or
// result, and a result register. Depends on iots_pkg.
module iots_back
    import iots_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    output logic      q_pop,
    input  op_t       q_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam int NDEV  = 2 ** DEV_W;
    localparam int NSLOT = NDEV * 4;

    logic [31:0] starts_reg [NDEV];
    logic [31:0] ends_reg   [NDEV];
    logic [63:0] since_reg  [NDEV];
    logic [63:0] busy_reg   [NDEV];
    logic [63:0] bytes_mem  [NSLOT];
    logic [63:0] ops_mem    [NSLOT];
    logic [63:0] dur_mem    [NSLOT];
    logic [63:0] tags_mem   [NSLOT];

    logic             ph_reg, ph_next;
    logic             clr_reg, clr_next;
    logic [DEV_W+1:0] clr_addr_reg, clr_addr_next;
    op_t              op_reg;
    logic [63:0]      bytes_rd_reg, ops_rd_reg, dur_rd_reg, tags_rd_reg;
    logic             ov_reg, ov_next;
    out_item_t        od_reg, od_next;
    logic             q_is_read;
    logic [DEV_W+1:0] rd_addr, tag_addr, kaddr, taddr;
    logic [DEV_W-1:0] d;
    logic [2:0]       grp;
    logic [1:0]       sub;
    logic [63:0]      sel_value;
    logic             upd;

    assign d     = op_reg.item.device;
    assign kaddr = {d, op_reg.item.transfer_kind};
    assign taddr = {d, op_reg.item.tag_kind};
    assign grp   = op_reg.item.stat_select[4:2];
    assign sub   = op_reg.item.stat_select[1:0];
    assign upd   = ph_reg && op_reg.dev_ok;

    assign q_is_read = (q_data.item.cmd == CMD_READ);
    assign rd_addr   = {q_data.item.device,
                        q_is_read ? q_data.item.stat_select[1:0] : q_data.item.transfer_kind};
    assign tag_addr  = {q_data.item.device,
                        q_is_read ? q_data.item.stat_select[1:0] : q_data.item.tag_kind};

    assign q_pop     = q_valid && !ph_reg && !clr_reg && !(q_is_read && ov_reg && out_stall);
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    always_comb
    begin
        ph_next       = q_pop;
        clr_next      = clr_reg && (clr_addr_reg != '1);
        clr_addr_next = clr_reg ? clr_addr_reg + (DEV_W+2)'(1) : clr_addr_reg;
    end

    always_comb
    begin
        sel_value = 64'd0;
        if (op_reg.dev_ok)
        begin
            case (grp)
                GRP_CNT:
                begin
                    case (sub)
                        SEL_STARTS[1:0]: sel_value = {32'd0, starts_reg[d]};
                        SEL_ENDS[1:0]:   sel_value = {32'd0, ends_reg[d]};
                        SEL_BUSY[1:0]:   sel_value = busy_reg[d];
                        SEL_SINCE[1:0]:  sel_value = since_reg[d];
                        default:         sel_value = 64'd0;
                    endcase
                end
                GRP_BYTES: sel_value = bytes_rd_reg;
                GRP_OPS:   sel_value = ops_rd_reg;
                GRP_DUR:   sel_value = dur_rd_reg;
                GRP_TAGS:  sel_value = (sub != TAG_NONE) ? tags_rd_reg : 64'd0;
                default:   sel_value = 64'd0;
            endcase
        end
        ov_next = ov_reg && out_stall;
        od_next = od_reg;
        if (ph_reg && op_reg.item.cmd == CMD_READ)
        begin
            ov_next = 1'b1;
            od_next.device_echo = d;
            od_next.stat_value  = sel_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            op_reg       <= q_data;
            bytes_rd_reg <= bytes_mem[rd_addr];
            ops_rd_reg   <= ops_mem[rd_addr];
            dur_rd_reg   <= dur_mem[rd_addr];
            tags_rd_reg  <= tags_mem[tag_addr];
        end
        od_reg <= od_next;
        if (clr_reg)
        begin
            bytes_mem[clr_addr_reg] <= '0;
            ops_mem[clr_addr_reg]   <= '0;
            dur_mem[clr_addr_reg]   <= '0;
            tags_mem[clr_addr_reg]  <= '0;
        end
        else if (upd && op_reg.item.cmd == CMD_END)
        begin
            bytes_mem[kaddr] <= bytes_rd_reg + {32'd0, op_reg.item.byte_count};
            ops_mem[kaddr]   <= ops_rd_reg + 64'd1;
            if (op_reg.tag_ok)
            begin
                tags_mem[taddr] <= tags_rd_reg + 64'd1;
            end
            if (op_reg.item.has_start_time)
            begin
                dur_mem[kaddr] <= dur_rd_reg
                    + (op_reg.item.now_time - op_reg.item.start_time);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg       <= 1'b0;
            ov_reg       <= 1'b0;
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
            for (int i = 0; i < NDEV; i++)
            begin
                starts_reg[i] <= '0;
                ends_reg[i]   <= '0;
                since_reg[i]  <= '0;
                busy_reg[i]   <= '0;
            end
        end
        else
        begin
            ph_reg       <= ph_next;
            ov_reg       <= ov_next;
            clr_reg      <= clr_next;
            clr_addr_reg <= clr_addr_next;
            if (upd)
            begin
                case (op_reg.item.cmd)
                    CMD_START:
                    begin
                        if (starts_reg[d] == ends_reg[d])
                        begin
                            since_reg[d] <= op_reg.item.now_time;
                        end
                        starts_reg[d] <= starts_reg[d] + 32'd1;
                    end
                    CMD_END:
                    begin
                        busy_reg[d] <= busy_reg[d]
                            + (op_reg.item.now_time - since_reg[d]);
                        since_reg[d] <= op_reg.item.now_time;
                        ends_reg[d]  <= ends_reg[d] + 32'd1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

[hw/rtl/io_transaction_statistics_top.sv]
// Top level of the I/O transaction statistics block: front queue and
// counter back end. Depends on iots_pkg, iots_front, iots_back.
//
//  channel   direction  handshake          payload
//  in        request    in_valid/in_stall  in_data (in_item_t)
//  out       result     out_valid/out_stall out_data (out_item_t)
//  cfg       write      cfg_we             cfg_wdata (16 bit mask)
//
// In the back end each request has a registered table read, then update or
// result, and no new request is taken until it is done; a read result then
// goes to the result register. Two requests queue ahead of the back end.
// Reset clears the mask and small counters at once; the counter memories
// clear in a pass over all 64 slots, during which the back end holds. An
// output stall holds a waiting result and blocks reads; starts and ends proceed.
module io_transaction_statistics_top
    import iots_pkg::*;
#(
    parameter int NUM_DEVICES = DEFAULT_NUM_DEVICES
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_data,
    input  logic              cfg_we,
    input  logic [MASK_W-1:0] cfg_wdata
);

    logic [MASK_W-1:0] mask_reg;
    logic              q_valid, q_pop;
    op_t               q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (cfg_we)
        begin
            mask_reg <= cfg_wdata;
        end
    end

    iots_front #(.NUM_DEVICES(NUM_DEVICES)) u_front
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_data(in_data), .mask(mask_reg), .q_valid(q_valid), .q_pop(q_pop),
        .q_data(q_data)
    );

    iots_back u_back
    (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop),
        .q_data(q_data), .out_valid(out_valid), .out_stall(out_stall),
        .out_data(out_data)
    );

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed under stall");
    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && q_data.item.cmd == CMD_READ |-> ##2 out_valid)
        else $error("read gave no result");

endmodule
